### src/ifa_pkg.sv
// ifa_pkg: shared codes, ASCII constants and helpers for the integer
// format-to-ASCII block. No dependencies.
package ifa_pkg;

  localparam logic [2:0] CONV_D    = 3'd0;
  localparam logic [2:0] CONV_O    = 3'd1;
  localparam logic [2:0] CONV_U    = 3'd2;
  localparam logic [2:0] CONV_X    = 3'd3;
  localparam logic [2:0] CONV_XU   = 3'd4;
  localparam logic [2:0] CONV_P    = 3'd5;
  localparam logic [2:0] CONV_C    = 3'd6;
  localparam logic [2:0] CONV_NONE = 3'd7;

  localparam logic [1:0] LEN_H = 2'd1;

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam int PTR_DIGITS = 8;

  // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic       load;
    logic [1:0] base;
  } div_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end
    return (upper ? 8'h37 : 8'h57) + d8;
  endfunction

endpackage

### src/ifa_ifs.sv
// Channel interfaces for the integer format-to-ASCII block: the parsed
// conversion request and the outgoing character stream. No dependencies.
interface ifa_fmt_if;
  logic              valid;
  logic              ready;
  logic [2:0]        conversion;
  logic [1:0]        length_mod;
  logic              left_justify;
  logic              plus_flag;
  logic              space_flag;
  logic              alt_flag;
  logic              zero_flag;
  logic [5:0]        field_width;
  logic signed [6:0] precision;
  logic [31:0]       value;

  modport source (
    output valid, conversion, length_mod, left_justify, plus_flag, space_flag,
    output alt_flag, zero_flag, field_width, precision, value,
    input  ready
  );
  modport sink (
    input  valid, conversion, length_mod, left_justify, plus_flag, space_flag,
    input  alt_flag, zero_flag, field_width, precision, value,
    output ready
  );
endinterface

interface ifa_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

### src/ifa_divider.sv
// ifa_divider: one divide-by-base step (8, 10 or 16) giving quotient and
// remainder digit. Decimal uses a registered reciprocal multiply. Uses ifa_pkg.
module ifa_divider import ifa_pkg::*; (
  input  logic        clk,
  input  div_ctrl_t   ctrl,
  input  logic [31:0] t,
  output logic [31:0] q,
  output logic [3:0]  rem
);

  logic [63:0] prod;
  logic [2:0]  q_lo;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= 64'(t) * 64'(RECIP10);
    end
  end

  assign q_lo = prod[37:35];

  always_comb begin
    unique case (ctrl.base)
      BASE_OCT: begin
        q   = {3'b0, t[31:3]};
        rem = {1'b0, t[2:0]};
      end
      BASE_HEX: begin
        q   = {4'b0, t[31:4]};
        rem = t[3:0];
      end
      BASE_DEC: begin
        q   = {3'b0, prod[63:35]};
        // t - 10q fits in four bits
        rem = t[3:0] - {q_lo[0], 3'b0} - {q_lo, 1'b0};
      end
      default: begin
        q   = '0;
        rem = '0;
      end
    endcase
  end

endmodule

### src/integer_format_to_ascii.sv
// integer_format_to_ascii: printf-style integer conversion to a character
// stream. Depends on ifa_pkg, ifa_ifs (channels) and ifa_divider.
//
// Takes one parsed conversion (d/i, o, u, x, X, p, c with flags, width and
// precision) and sends its characters one per transfer, last marked. One
// request is in work at a time; the request channel is ready only when idle,
// while the final character may still wait in the output register. Digits
// come from a single divide-by-base unit, least significant first: octal and
// hex take one divide step per digit, decimal a registered reciprocal
// multiply and then the remainder step. After the digits the layout is sized
// and bounded, then one character goes out per cycle while the sink is ready.
// Conversion code 7 and an empty result give no transfers.
module integer_format_to_ascii import ifa_pkg::*; #(
  parameter int MAX_FIELD   = 60,
  parameter int DIGIT_SLOTS = 11
) (
  input logic              clk,
  input logic              rst,
  ifa_fmt_if.sink          fmt,
  ifa_char_if.source       chars
);

  localparam int CW_RAW = $clog2(MAX_FIELD + DIGIT_SLOTS + 5);
  localparam int CW     = (CW_RAW < 7) ? 7 : CW_RAW;
  localparam int ND_W   = $clog2(DIGIT_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIG   = 3'd2;
  localparam logic [2:0] S_SIZE  = 3'd3;
  localparam logic [2:0] S_BOUND = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]      state;
  logic [1:0]      base;
  logic            upper;
  logic            left;
  logic            zpad;
  logic            alt;
  logic            octal;
  logic            prec_given;
  logic [CW-1:0]   prec;
  logic [CW-1:0]   wid;
  logic            sign_on;
  logic [7:0]      signch;
  logic            nonzero;
  logic [31:0]     t;
  logic [ND_W-1:0] nd;
  logic [CW-1:0]   nz;
  logic            pf_on;
  logic [CW-1:0]   pad;
  logic [CW-1:0]   b1, b2, b3, b5, b6, n_total;
  logic [CW-1:0]   idx;
  logic            ovalid;
  logic [7:0]      ochar;
  logic            olast;
  logic [7:0]      slots [DIGIT_SLOTS];

  // request preprocessing
  logic            is_ptr, is_chr, neg, prec_in_given, zpad_in, alt_in, empty_in;
  logic [31:0]     vm, va;
  logic [CW-1:0]   prec_in, wid_in;
  logic [1:0]      base_in;

  always_comb begin
    is_ptr = fmt.conversion == CONV_P;
    is_chr = fmt.conversion == CONV_C;
    vm     = fmt.value;
    if (fmt.length_mod == LEN_H && !is_ptr) begin
      vm = {{16{fmt.conversion == CONV_D && fmt.value[15]}}, fmt.value[15:0]};
    end
    neg = fmt.conversion == CONV_D && vm[31];
    va  = neg ? 32'(32'd0 - vm) : vm;
    prec_in_given = is_ptr || (!is_chr && !fmt.precision[6]);
    if (is_ptr) begin
      prec_in = CW'(PTR_DIGITS);
    end else if (CW'(fmt.precision[5:0]) > CW'(MAX_FIELD)) begin
      prec_in = CW'(MAX_FIELD);
    end else begin
      prec_in = CW'(fmt.precision[5:0]);
    end
    wid_in = (CW'(fmt.field_width) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                     : CW'(fmt.field_width);
    zpad_in  = fmt.zero_flag && !fmt.left_justify && (is_chr || !prec_in_given);
    alt_in   = is_ptr || (fmt.alt_flag && !is_chr);
    empty_in = prec_in_given && prec_in == '0 && va == '0;
    priority case (fmt.conversion)
      CONV_O:        base_in = BASE_OCT;
      CONV_D,
      CONV_U:        base_in = BASE_DEC;
      default:       base_in = BASE_HEX;
    endcase
  end

  // shared divide step
  div_ctrl_t   dctrl;
  logic [31:0] q;
  logic [3:0]  rem;

  assign dctrl.load = state == S_MUL;
  assign dctrl.base = base;

  ifa_divider u_div (
    .clk  (clk),
    .ctrl (dctrl),
    .t    (t),
    .q    (q),
    .rem  (rem)
  );

  logic dig_done;
  assign dig_done = q == '0 || nd == ND_W'(DIGIT_SLOTS - 1);

  // layout sizing
  logic [CW-1:0] nd_c, nz_c, total_c, pad_c;
  logic [CW-1:0] lp, sg, pf, zp, rp;

  always_comb begin
    nd_c = CW'(nd);
    nz_c = (prec_given && prec > nd_c) ? CW'(prec - nd_c) : '0;
    if (alt && octal && nz_c == '0 && (nd == '0 || nonzero)) begin
      nz_c = CW'(1);
    end
    total_c = CW'(sign_on) + ((alt && base == BASE_HEX && nonzero) ? CW'(2) : '0)
              + nz_c + nd_c;
    pad_c   = (wid > total_c) ? CW'(wid - total_c) : '0;
    lp = (!left && !zpad) ? pad : '0;
    sg = CW'(sign_on);
    pf = pf_on ? CW'(2) : '0;
    zp = (!left && zpad) ? pad : '0;
    rp = left ? pad : '0;
  end

  logic [CW-1:0] b5_c;
  assign b5_c = lp + sg + pf + zp + nz;

  // character for the current position
  logic [7:0] emit_ch;
  logic       in_digits;
  logic       emit;

  always_comb begin
    in_digits = 1'b0;
    priority if (idx < b1) begin
      emit_ch = CH_SPACE;
    end else if (idx < b2) begin
      emit_ch = signch;
    end else if (idx < b3) begin
      emit_ch = (idx == b2) ? CH_ZERO : (upper ? CH_UX : CH_LX);
    end else if (idx < b5) begin
      emit_ch = CH_ZERO;
    end else if (idx < b6) begin
      emit_ch   = slots[0];
      in_digits = 1'b1;
    end else begin
      emit_ch = CH_SPACE;
    end
  end

  assign emit = state == S_EMIT && (!ovalid || chars.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (chars.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (fmt.valid && fmt.conversion != CONV_NONE) begin
            if (is_chr || empty_in) begin
              state <= S_SIZE;
            end else if (base_in == BASE_DEC) begin
              state <= S_MUL;
            end else begin
              state <= S_DIG;
            end
          end
        end
        S_MUL: state <= S_DIG;
        S_DIG: begin
          if (dig_done) begin
            state <= S_SIZE;
          end else if (base == BASE_DEC) begin
            state <= S_MUL;
          end else begin
            state <= S_DIG;
          end
        end
        S_SIZE: state <= S_BOUND;
        S_BOUND: begin
          state <= (b5_c + nd_c + rp == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (emit && idx == n_total - CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        base       <= base_in;
        upper      <= fmt.conversion != CONV_X;
        left       <= fmt.left_justify;
        zpad       <= zpad_in;
        alt        <= alt_in;
        octal      <= fmt.conversion == CONV_O;
        prec_given <= prec_in_given;
        prec       <= prec_in;
        wid        <= wid_in;
        sign_on    <= fmt.conversion == CONV_D &&
                      (neg || fmt.plus_flag || fmt.space_flag);
        signch     <= neg ? CH_MINUS : (fmt.plus_flag ? CH_PLUS : CH_SPACE);
        nonzero    <= va != '0;
        t          <= va;
        nd         <= is_chr ? ND_W'(1) : '0;
        slots[0]   <= fmt.value[7:0];
      end
      S_DIG: begin
        slots[0] <= digit_char(rem, upper);
        for (int k = 1; k < DIGIT_SLOTS; k++) begin
          slots[k] <= slots[k-1];
        end
        t  <= q;
        nd <= nd + ND_W'(1);
      end
      S_SIZE: begin
        nz    <= nz_c;
        pf_on <= alt && base == BASE_HEX && nonzero;
        pad   <= pad_c;
      end
      S_BOUND: begin
        b1      <= lp;
        b2      <= lp + sg;
        b3      <= lp + sg + pf;
        b5      <= b5_c;
        b6      <= b5_c + nd_c;
        n_total <= b5_c + nd_c + rp;
        idx     <= '0;
      end
      S_EMIT: begin
        if (emit) begin
          ochar <= emit_ch;
          olast <= idx == n_total - CW'(1);
          idx   <= idx + CW'(1);
          if (in_digits) begin
            for (int k = 0; k < DIGIT_SLOTS - 1; k++) begin
              slots[k] <= slots[k+1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign fmt.ready       = state == S_IDLE;
  assign chars.valid     = ovalid;
  assign chars.character = ochar;
  assign chars.last      = olast;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (fmt.valid && fmt.ready && fmt.conversion != CONV_NONE) |=> !fmt.ready)
    else $error("request channel ready while a conversion is in work");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (idx < n_total))
    else $error("character position beyond the conversion length");

  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= ND_W'(DIGIT_SLOTS))
    else $error("digit count exceeds the digit slots");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) == S_EMIT && state == S_IDLE) |-> (ovalid && olast))
    else $error("conversion ended without a last transfer");
`endif

endmodule
